// File: src/pcps_pkg.sv
`default_nettype none

package pcps_pkg;

  // Input capture width
  localparam int CAPTURE_BITS = 16;

  // Field widths
  localparam int DUTY_BITS   = 10;
  localparam int FREQ_BITS   = 28;
  localparam int PEDAL_BITS  = 7;
  localparam int CLK_BITS    = 29;
  localparam int SLOPE_BITS  = 16;
  localparam int OFFSET_BITS = 24;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = CLK_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CORE_CLOCK   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_SLOPE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_OFFSET = 2'd2;

  localparam logic [CLK_BITS-1:0]           CORE_CLOCK_RST   = CLK_BITS'(168000000);
  localparam logic signed [SLOPE_BITS-1:0]  SCALE_SLOPE_RST  = SLOPE_BITS'(10);
  localparam logic signed [OFFSET_BITS-1:0] SCALE_OFFSET_RST = '0;

  // Arithmetic constants
  localparam int DUTY_FULL = 1000;
  localparam int PCT_DIV   = 100;
  localparam int PCT_MAX   = 100;

  // Dividend of the duty division: high * 1000
  localparam int DUTY_N_BITS = CAPTURE_BITS + DUTY_BITS;

  // Pedal arithmetic widths
  localparam int PROD_BITS = SLOPE_BITS + DUTY_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;

  // Sum window that maps to 1..100 after the divide by 100
  localparam int PED_LO_VAL = PCT_DIV;
  localparam int PED_HI_VAL = PCT_DIV * (PCT_MAX + 1);
  localparam int PED_V_BITS = $clog2(PED_HI_VAL);

  // Divide by 100 as a multiply by a reciprocal: exact for sums below 2^PED_V_BITS
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_BITS  = 13;
  localparam logic [RECIP_BITS-1:0] RECIP_100 = RECIP_BITS'(5243);
  localparam int RPROD_BITS  = PED_V_BITS + RECIP_BITS;

  // Pipeline depth: one stage per frequency quotient bit after the input register
  localparam int NUM_STAGES = FREQ_BITS;

  typedef struct packed {
    logic [CAPTURE_BITS-1:0]      per;
    logic                         zero;
    logic                         sat;
    logic [CAPTURE_BITS-1:0]      d_rem;
    logic [DUTY_BITS-1:0]         d_lo;
    logic [DUTY_BITS-1:0]         d_q;
    logic [DUTY_BITS-1:0]         duty;
    logic [CAPTURE_BITS-1:0]      f_rem;
    logic [FREQ_BITS-1:0]         f_q;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [SUM_BITS-1:0]   sum;
    logic                         ped_hi;
    logic                         ped_lo;
    logic [RPROD_BITS-1:0]        rprod;
    logic [PEDAL_BITS-1:0]        pedal;
  } stage_t;

endpackage

`default_nettype wire

// File: src/pwm_capture_pedal_scaler.sv
`default_nettype none

// PWM capture pedal scaler. Each input transaction carries one captured PWM
// period and high time in timer ticks; each produces exactly one output
// transaction with the duty cycle in permille (saturated at 1000), the PWM
// frequency in hertz (core clock over twice the period) and the calibrated
// pedal position in percent, clamped to 0..100. A zero period reports duty 0
// and frequency 0, and the pedal then follows the offset alone. The block
// takes a new transaction every clock while the pipeline has room; the
// frequency divider resolves one quotient bit per pipeline stage over 28
// stages behind the input register. Stalls on the output ripple back stage
// by stage, so empty stages keep filling and inputs keep being taken while
// a result waits.
// Registers: index 0 core clock in hertz (reset 168000000), index 1 slope in
// hundredths of percent per permille (signed, reset 10), index 2 offset in
// hundredths of percent (signed, reset 0). Write them only while idle;
// unknown indexes are dropped.

module pwm_capture_pedal_scaler (
  input  wire                                 clk,
  input  wire                                 rst_n,

  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [pcps_pkg::CAPTURE_BITS-1:0]   in_period_ticks,
  input  wire  [pcps_pkg::CAPTURE_BITS-1:0]   in_high_ticks,

  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [pcps_pkg::DUTY_BITS-1:0]      out_duty_permille,
  output logic [pcps_pkg::FREQ_BITS-1:0]      out_frequency_hz,
  output logic [pcps_pkg::PEDAL_BITS-1:0]     out_pedal_percent,

  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [pcps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [pcps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import pcps_pkg::*;

  localparam int NS = NUM_STAGES;
  localparam int ND = DUTY_BITS;

  // Stage roles behind the duty divider
  localparam int S_MUL  = ND + 1;   // final duty and slope multiply
  localparam int S_SUM  = ND + 2;   // add offset
  localparam int S_RCP  = ND + 3;   // clamp window and reciprocal multiply
  localparam int S_PED  = ND + 4;   // pick the quotient

  localparam logic signed [SUM_BITS-1:0] PED_LO = SUM_BITS'(PED_LO_VAL);
  localparam logic signed [SUM_BITS-1:0] PED_HI = SUM_BITS'(PED_HI_VAL);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CLK_BITS-1:0]           core_clock_r;
  logic signed [SLOPE_BITS-1:0]  scale_slope_r;
  logic signed [OFFSET_BITS-1:0] scale_offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_clock_r   <= CORE_CLOCK_RST;
      scale_slope_r  <= SCALE_SLOPE_RST;
      scale_offset_r <= SCALE_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CORE_CLOCK:   core_clock_r   <= cfg_data[CLK_BITS-1:0];
        CFG_SCALE_SLOPE:  scale_slope_r  <= cfg_data[SLOPE_BITS-1:0];
        CFG_SCALE_OFFSET: scale_offset_r <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clock / (2 * period) == (clock >> 1) / period
  logic [FREQ_BITS-1:0] clk_half;
  assign clk_half = core_clock_r[CLK_BITS-1:1];

  // ---------------------------------------------------------------------
  // Pipeline: stage 0 is the input register, stages 1..NS each resolve one
  // frequency quotient bit; the duty divider and pedal arithmetic ride in the
  // early stages and the later stages just carry their results.
  // ---------------------------------------------------------------------
  stage_t          st_r   [0:NS];
  stage_t          st_nxt [0:NS];
  logic [NS:0]     v_r;
  logic [NS+1:0]   rdy;

  // A stage can load when it is empty or its content is moving on
  assign rdy[NS+1] = !out_stall;

  genvar g;
  generate
    for (g = 0; g <= NS; g++) begin : g_rdy
      assign rdy[g] = !v_r[g] || rdy[g+1];
    end
  endgenerate

  assign in_stall = !rdy[0];

  // Input register: form high*1000 and the special-case flags
  logic [DUTY_N_BITS-1:0] duty_n;

  always_comb begin
    duty_n = DUTY_N_BITS'(in_high_ticks) * DUTY_N_BITS'(DUTY_FULL);
    st_nxt[0]        = '0;
    st_nxt[0].per    = in_period_ticks;
    st_nxt[0].zero   = (in_period_ticks == '0);
    // high >= period gives a quotient of at least 1000
    st_nxt[0].sat    = (in_high_ticks >= in_period_ticks);
    st_nxt[0].d_rem  = duty_n[DUTY_N_BITS-1:ND];
    st_nxt[0].d_lo   = duty_n[ND-1:0];
  end

  generate
    for (g = 1; g <= NS; g++) begin : g_stage
      localparam int FB = NS - g;

      logic [CAPTURE_BITS:0] f_t;
      logic [CAPTURE_BITS:0] f_d;
      logic [CAPTURE_BITS:0] d_t;
      logic [CAPTURE_BITS:0] d_d;

      always_comb begin
        st_nxt[g] = st_r[g-1];

        // One restoring step of the frequency divider
        f_t = {st_r[g-1].f_rem, clk_half[FB]};
        f_d = f_t - {1'b0, st_r[g-1].per};
        if (f_t >= {1'b0, st_r[g-1].per}) begin
          st_nxt[g].f_rem = f_d[CAPTURE_BITS-1:0];
          st_nxt[g].f_q   = {st_r[g-1].f_q[FREQ_BITS-2:0], 1'b1};
        end else begin
          st_nxt[g].f_rem = f_t[CAPTURE_BITS-1:0];
          st_nxt[g].f_q   = {st_r[g-1].f_q[FREQ_BITS-2:0], 1'b0};
        end

        // One restoring step of the duty divider (quotient below 1000 when not saturated)
        d_t = {st_r[g-1].d_rem, st_r[g-1].d_lo[ND-1]};
        d_d = d_t - {1'b0, st_r[g-1].per};
        if (g <= ND) begin
          st_nxt[g].d_lo = {st_r[g-1].d_lo[ND-2:0], 1'b0};
          if (d_t >= {1'b0, st_r[g-1].per}) begin
            st_nxt[g].d_rem = d_d[CAPTURE_BITS-1:0];
            st_nxt[g].d_q   = {st_r[g-1].d_q[ND-2:0], 1'b1};
          end else begin
            st_nxt[g].d_rem = d_t[CAPTURE_BITS-1:0];
            st_nxt[g].d_q   = {st_r[g-1].d_q[ND-2:0], 1'b0};
          end
        end

        if (g == S_MUL) begin
          if (st_r[g-1].zero) begin
            st_nxt[g].duty = '0;
          end else if (st_r[g-1].sat) begin
            st_nxt[g].duty = ND'(DUTY_FULL);
          end else begin
            st_nxt[g].duty = st_r[g-1].d_q;
          end
          st_nxt[g].prod = PROD_BITS'(scale_slope_r * $signed({1'b0, st_nxt[g].duty}));
        end

        if (g == S_SUM) begin
          st_nxt[g].sum = SUM_BITS'(st_r[g-1].prod) + SUM_BITS'(scale_offset_r);
        end

        if (g == S_RCP) begin
          st_nxt[g].ped_hi = (st_r[g-1].sum >= PED_HI);
          st_nxt[g].ped_lo = (st_r[g-1].sum < PED_LO);
          st_nxt[g].rprod  = RPROD_BITS'(st_r[g-1].sum[PED_V_BITS-1:0]) * RPROD_BITS'(RECIP_100);
        end

        if (g == S_PED) begin
          if (st_r[g-1].ped_hi) begin
            st_nxt[g].pedal = PEDAL_BITS'(PCT_MAX);
          end else if (st_r[g-1].ped_lo) begin
            st_nxt[g].pedal = '0;
          end else begin
            st_nxt[g].pedal = st_r[g-1].rprod[RECIP_SHIFT +: PEDAL_BITS];
          end
        end
      end
    end
  endgenerate

  // Stage registers: valid travels with the payload, hold while stalled
  generate
    for (g = 0; g <= NS; g++) begin : g_reg
      logic v_nxt;

      if (g == 0) begin : g_src0
        assign v_nxt = in_valid;
      end else begin : g_srcn
        assign v_nxt = v_r[g-1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (rdy[g]) begin
          v_r[g] <= v_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          st_r[g] <= st_nxt[g];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Output
  // ---------------------------------------------------------------------
  assign out_valid         = v_r[NS];
  assign out_duty_permille = st_r[NS].duty;
  assign out_frequency_hz  = st_r[NS].zero ? '0 : st_r[NS].f_q;
  assign out_pedal_percent = st_r[NS].pedal;

endmodule

`default_nettype wire

// File: tb/sv/pcps_result_checker.sv
`default_nettype none

module pcps_result_checker (
  input  wire                                 clk,
  input  wire                                 rst_n,

  input  wire                                 in_valid,
  input  wire                                 in_stall,
  input  wire  [pcps_pkg::CAPTURE_BITS-1:0]   in_period_ticks,
  input  wire  [pcps_pkg::CAPTURE_BITS-1:0]   in_high_ticks,

  input  wire                                 out_valid,
  input  wire                                 out_stall,
  input  wire  [pcps_pkg::DUTY_BITS-1:0]      out_duty_permille,
  input  wire  [pcps_pkg::FREQ_BITS-1:0]      out_frequency_hz,
  input  wire  [pcps_pkg::PEDAL_BITS-1:0]     out_pedal_percent,

  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire  [pcps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [pcps_pkg::CFG_DATA_BITS-1:0]  cfg_data,

  output int unsigned                         fail_count,
  output int unsigned                         pending,
  output int unsigned                         compared
);

  import pcps_pkg::*;

  typedef struct packed {
    logic [DUTY_BITS-1:0]  duty;
    logic [FREQ_BITS-1:0]  freq;
    logic [PEDAL_BITS-1:0] pedal;
  } pwm_reading_t;

  logic [CLK_BITS-1:0]           clock_hz;
  logic signed [SLOPE_BITS-1:0]  slope;
  logic signed [OFFSET_BITS-1:0] offset;

  pwm_reading_t awaited_readings[$];
  int unsigned  fails   = 0;
  int unsigned  checked = 0;

  // Duty, frequency and calibrated pedal position for one capture pair
  function automatic pwm_reading_t predict_reading(input logic [CAPTURE_BITS-1:0] per,
                                                   input logic [CAPTURE_BITS-1:0] hi);
    pwm_reading_t r;
    longint       duty;
    longint       pedal;
    r    = '0;
    duty = 0;
    if (per != '0) begin
      duty   = (longint'(hi) * DUTY_FULL) / longint'(per);
      r.freq = FREQ_BITS'(longint'(clock_hz) / (2 * longint'(per)));
    end
    if (duty > DUTY_FULL) duty = DUTY_FULL;
    r.duty = DUTY_BITS'(duty);
    // signed division truncates toward zero, then clamp
    pedal = (longint'(slope) * duty + longint'(offset)) / PCT_DIV;
    if (pedal > PCT_MAX) pedal = PCT_MAX;
    if (pedal < 0) pedal = 0;
    r.pedal = PEDAL_BITS'(pedal);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pwm_reading_t want;
    if (!rst_n) begin
      clock_hz = CORE_CLOCK_RST;
      slope    = SCALE_SLOPE_RST;
      offset   = SCALE_OFFSET_RST;
      awaited_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_readings.size() == 0) begin
          fails++;
          $error("unexpected result: duty %0d, frequency %0d, pedal %0d",
                 out_duty_permille, out_frequency_hz, out_pedal_percent);
        end else begin
          want = awaited_readings.pop_front();
          checked++;
          if (out_duty_permille !== want.duty) begin
            fails++;
            $error("duty_permille: expected %0d, got %0d", want.duty, out_duty_permille);
          end
          if (out_frequency_hz !== want.freq) begin
            fails++;
            $error("frequency_hz: expected %0d, got %0d", want.freq, out_frequency_hz);
          end
          if (out_pedal_percent !== want.pedal) begin
            fails++;
            $error("pedal_percent: expected %0d, got %0d", want.pedal, out_pedal_percent);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_readings.push_back(predict_reading(in_period_ticks, in_high_ticks));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CORE_CLOCK:   clock_hz = cfg_data[CLK_BITS-1:0];
          CFG_SCALE_SLOPE:  slope    = cfg_data[SLOPE_BITS-1:0];
          CFG_SCALE_OFFSET: offset   = cfg_data[OFFSET_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= awaited_readings.size();
    compared   <= checked;
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_pwm_capture_pedal_scaler.sv
`default_nettype none

module tb_pwm_capture_pedal_scaler;
  import pcps_pkg::*;

  // Index that decodes to no register: writes to it must leave every setting alone
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int NUM_SETTINGS     = 8;
  localparam int CAPTURES_PER_SET = 190;
  // Long output hold-off: far longer than the pipeline is deep, so the input backs up
  localparam int HOLD_CYCLES      = 250;
  // Wait out a stretch longer than the pipeline at the end to catch stray results
  localparam int DRAIN_CYCLES     = 40;
  localparam int LIMIT_CYCLES     = 400000;

  logic                     clk = 1'b0;
  logic                     rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic [CAPTURE_BITS-1:0]  in_period_ticks;
  logic [CAPTURE_BITS-1:0]  in_high_ticks;

  logic                     out_valid;
  logic                     out_stall;
  logic [DUTY_BITS-1:0]     out_duty_permille;
  logic [FREQ_BITS-1:0]     out_frequency_hz;
  logic [PEDAL_BITS-1:0]    out_pedal_percent;

  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;

  // Shared between the sender and the receiver: idle probability in percent,
  // and a one-shot request for the long output hold-off
  int unsigned idle_pct     = 0;
  bit          rx_hold_req  = 1'b0;
  int unsigned captures_sent = 0;

  always #6 clk = ~clk;

  pwm_capture_pedal_scaler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_period_ticks   (in_period_ticks),
    .in_high_ticks     (in_high_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_duty_permille (out_duty_permille),
    .out_frequency_hz  (out_frequency_hz),
    .out_pedal_percent (out_pedal_percent),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  pcps_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_period_ticks   (in_period_ticks),
    .in_high_ticks     (in_high_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_duty_permille (out_duty_permille),
    .out_frequency_hz  (out_frequency_hz),
    .out_pedal_percent (out_pedal_percent),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .compared          (compared)
  );

  // Offer one capture pair and hold it until the block takes it. Afterwards
  // drop valid for a short random burst, or leave it high so the next call
  // can present its payload at once.
  task automatic send_capture(input logic [CAPTURE_BITS-1:0] period,
                              input logic [CAPTURE_BITS-1:0] high);
    in_valid        <= 1'b1;
    in_period_ticks <= period;
    in_high_ticks   <= high;
    do @(posedge clk); while (in_stall);
    captures_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Random capture pair, weighted towards well-formed PWM (high within period)
  task automatic send_random_capture();
    logic [CAPTURE_BITS-1:0] period;
    logic [CAPTURE_BITS-1:0] high;
    int unsigned             pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // no signal: zero period with any high time
      period = '0;
      high   = CAPTURE_BITS'($urandom);
    end else if (pick < 25) begin
      // anything goes, high time often longer than the period
      period = CAPTURE_BITS'($urandom);
      high   = CAPTURE_BITS'($urandom);
    end else if (pick < 35) begin
      // very short periods: large frequencies and coarse duty steps
      period = CAPTURE_BITS'($urandom_range(1, 15));
      high   = CAPTURE_BITS'($urandom_range(0, 20));
    end else begin
      period = CAPTURE_BITS'($urandom_range(1, 65535));
      high   = CAPTURE_BITS'($urandom_range(0, period));
    end
    send_capture(period, high);
  endtask

  // Wait until every transaction in flight has produced its result. The
  // first edge lets the checker account for the last accepted capture.
  task automatic wait_results_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Leave valid high so back-to-back writes need no second assignment in
  // one step; the caller drops it after the last write.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0]  idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input int unsigned setting);
    case (setting)
      0: begin
        // reset calibration, but with junk to an unused index first
        write_register(CFG_UNUSED_IDX, CFG_DATA_BITS'($urandom));
        write_register(CFG_CORE_CLOCK, CFG_DATA_BITS'(168000000));
        write_register(CFG_SCALE_SLOPE, CFG_DATA_BITS'(10));
        write_register(CFG_SCALE_OFFSET, '0);
      end
      1: begin
        // zero clock; largest slope and offset, upper data bits set to junk
        write_register(CFG_CORE_CLOCK, '0);
        write_register(CFG_SCALE_SLOPE, {13'h1ABC, 16'h7FFF});
        write_register(CFG_SCALE_OFFSET, {5'h15, 24'h7FFFFF});
      end
      2: begin
        // all clock bits set; most negative slope and offset
        write_register(CFG_CORE_CLOCK, '1);
        write_register(CFG_SCALE_SLOPE, CFG_DATA_BITS'(16'h8000));
        write_register(CFG_SCALE_OFFSET, CFG_DATA_BITS'(24'h800000));
      end
      3: begin
        write_register(CFG_CORE_CLOCK, CFG_DATA_BITS'(1));
        write_register(CFG_SCALE_SLOPE, CFG_DATA_BITS'(1));
        write_register(CFG_SCALE_OFFSET, '0);
      end
      4: begin
        // 400 MHz core clock, typical calibration
        write_register(CFG_CORE_CLOCK, CFG_DATA_BITS'(400000000));
        write_register(CFG_SCALE_SLOPE, CFG_DATA_BITS'(11));
        write_register(CFG_SCALE_OFFSET, CFG_DATA_BITS'(-500));
        write_register(CFG_UNUSED_IDX, '1);
      end
      6: begin
        // every bit pattern goes
        write_register(CFG_CORE_CLOCK, CFG_DATA_BITS'($urandom));
        write_register(CFG_SCALE_SLOPE, CFG_DATA_BITS'($urandom));
        write_register(CFG_SCALE_OFFSET, CFG_DATA_BITS'($urandom));
      end
      default: begin
        // calibration-like: keeps the pedal value mostly inside 0..100
        write_register(CFG_CORE_CLOCK, CFG_DATA_BITS'($urandom_range(1000, 400000000)));
        write_register(CFG_SCALE_SLOPE, CFG_DATA_BITS'(int'($urandom_range(0, 600)) - 300));
        write_register(CFG_SCALE_OFFSET,
                       CFG_DATA_BITS'(int'($urandom_range(0, 60000)) - 30000));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Result sink: random stall bursts, plus one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        burst_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [CAPTURE_BITS-1:0] directed_period [20];
    logic [CAPTURE_BITS-1:0] directed_high   [20];
    directed_period = '{16'd0,     16'd0,     16'd65535, 16'd65535, 16'd1,
                        16'd1,     16'd1,     16'd2,     16'd3,     16'd65535,
                        16'd1000,  16'd1000,  16'd1000,  16'd999,   16'd32768,
                        16'd100,   16'd7,     16'd65534, 16'd40000, 16'd12345};
    directed_high   = '{16'd0,     16'd65535, 16'd65535, 16'd0,     16'd0,
                        16'd1,     16'd65535, 16'd1,     16'd2,     16'd65534,
                        16'd500,   16'd1001,  16'd999,   16'd1,     16'd16384,
                        16'd50,    16'd3,     16'd32767, 16'd40001, 16'd54321};

    // Hold every input at a known value from time zero
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_period_ticks <= '0;
    in_high_ticks   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed captures under the reset calibration: zero period, saturation
    // of the duty, extreme periods and a few mid-scale points
    idle_pct = 20;
    foreach (directed_period[i]) send_capture(directed_period[i], directed_high[i]);
    in_valid <= 1'b0;
    wait_results_drained();

    // Random captures under a sequence of register settings. Idle on both
    // sides except for a quiet middle setting and the final stretch.
    for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
      apply_setting(s);
      idle_pct = (s == 3 || s == NUM_SETTINGS - 1) ? 0 : 25;
      // fill the pipeline against a held output once, with the sender still busy
      if (s == 1) rx_hold_req = 1'b1;
      repeat (CAPTURES_PER_SET) send_random_capture();
      in_valid <= 1'b0;
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d capture pairs over %0d register settings; %0d results compared.",
             captures_sent, NUM_SETTINGS + 1, compared);
    $display("Output held off for %0d cycles once to back up the input.", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
